// ----- sv/mfs_pkg.sv -----
// mfs_pkg: shared constants and types of the multilevel fcfs schedule timing block
// no dependencies; imported by mfs_alu, mfs_table and the top level
package mfs_pkg;

	// default sizing of the record table and of the time fields
	localparam int MAX_PROCS_DEF = 16;
	localparam int TIME_BITS_DEF = 16;

	// fixed port widths
	localparam int ID_W       = 8;
	localparam int IN_TIME_W  = 16;
	localparam int OUT_TIME_W = 21;
	localparam int SUM_W      = 25;
	localparam int SUMB_W     = 20;

	// operation of the shared add/subtract unit
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

// ----- sv/mfs_alu.sv -----
// mfs_alu: shared add/subtract unit with borrow out, used for every key
// compare and every time computation; depends on mfs_pkg
module mfs_alu #(
	parameter int W = 25
) (
	input  mfs_pkg::alu_op_t op,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [W-1:0]     res,
	output logic             borrow
);
	import mfs_pkg::*;

	logic [W:0] full;

	// one wide adder, b inverted for subtract; borrow set when a < b
	always_comb begin
		case (op)
			ALU_ADD: full = {1'b0, a} + {1'b0, b};
			ALU_SUB: full = {1'b0, a} - {1'b0, b};
			default: full = {1'b0, a} + {1'b0, b};
		endcase
	end

	assign res    = full[W-1:0];
	assign borrow = (op == ALU_SUB) ? full[W] : 1'b0;

endmodule

// ----- sv/mfs_table.sv -----
// mfs_table: process record memory, one write port and one registered read port
// depends on mfs_pkg for house conventions only
module mfs_table #(
	parameter int DEPTH = 16,
	parameter int AB    = 4,
	parameter int DW    = 41
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AB-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AB-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);
	import mfs_pkg::*;

	logic [DW-1:0] mem_q [0:DEPTH-1];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- sv/multilevel_fcfs_schedule_timing.sv -----
// multilevel_fcfs_schedule_timing: top level, sequencer around the record
// table and the shared add/subtract unit; depends on mfs_pkg, mfs_alu, mfs_table
//
// usage:
//   input channel (in_valid / in_stall) takes one process record per item.
//   the table is kept sorted on load: system class ahead of user class,
//   ascending arrival within a class, equal arrivals in load order.
//   a record is inserted by stepping down over the stored records that sort
//   after it (one memory read and one compare per entry looked at), each moved
//   up one place, before the record is written into the gap.
//   a record that finds the table full is dropped and sets the dropped flag.
//   the record with last_record set starts the schedule: per process one
//   result item on the output channel (out_valid / out_stall), each read from
//   the table and worked out on the shared add/subtract unit before it is offered.
//   in_stall stays high from the accepted item until its work is done, and
//   for the whole schedule until the final result has been taken.
//   a stalled result holds all output fields; the sequencer waits on it.
//   after the final result the count, dropped flag and clock return to zero.
//   reset (arst_n low) empties the table and ends any schedule in flight.
module multilevel_fcfs_schedule_timing #(
	parameter int MAX_PROCS = mfs_pkg::MAX_PROCS_DEF,
	parameter int TIME_BITS = mfs_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mfs_pkg::ID_W-1:0]          process_id,
	input  logic [mfs_pkg::IN_TIME_W-1:0]     arrival,
	input  logic [mfs_pkg::IN_TIME_W-1:0]     burst,
	input  logic                              system_class,
	input  logic                              last_record,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mfs_pkg::ID_W-1:0]          result_id,
	output logic [mfs_pkg::OUT_TIME_W-1:0]    start_time,
	output logic [mfs_pkg::OUT_TIME_W-1:0]    completion_time,
	output logic [mfs_pkg::OUT_TIME_W-1:0]    turnaround,
	output logic [mfs_pkg::OUT_TIME_W-1:0]    waiting,
	output logic [mfs_pkg::OUT_TIME_W-1:0]    response,
	output logic [mfs_pkg::SUM_W-1:0]         sum_turnaround,
	output logic [mfs_pkg::SUM_W-1:0]         sum_waiting,
	output logic [mfs_pkg::SUMB_W-1:0]        sum_burst,
	output logic [mfs_pkg::OUT_TIME_W-1:0]    makespan,
	output logic                              dropped,
	output logic                              last_result
);
	import mfs_pkg::*;

	// stored time width, record layout and counter widths
	localparam int SW  = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
	localparam int DW  = 1 + ID_W + 2 * SW;
	localparam int AB  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW  = $clog2(MAX_PROCS + 1);
	localparam int RW  = SW + CW + 1;
	localparam int AW  = (RW > SUM_W) ? RW : SUM_W;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_INS_RD  = 13'b0000000000010,
		S_INS_CMP = 13'b0000000000100,
		S_SCH_RD  = 13'b0000000001000,
		S_ST      = 13'b0000000010000,
		S_CT      = 13'b0000000100000,
		S_TAT     = 13'b0000001000000,
		S_RT      = 13'b0000010000000,
		S_STAT    = 13'b0000100000000,
		S_SWT     = 13'b0001000000000,
		S_SBT     = 13'b0010000000000,
		S_OUT     = 13'b0100000000000,
		S_SPARE   = 13'b1000000000000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   idx_q;
	logic            overflow_q;
	logic            last_rec_q;
	logic            last_res_q;

	// record being loaded
	logic [ID_W-1:0] new_id_q;
	logic [SW-1:0]   new_arr_q;
	logic [SW-1:0]   new_bt_q;
	logic            new_cls_q;

	// record being scheduled and its results
	logic [ID_W-1:0] cur_id_q;
	logic [SW-1:0]   cur_arr_q;
	logic [SW-1:0]   cur_bt_q;
	logic [AW-1:0]   run_q;
	logic [AW-1:0]   st_q;
	logic [AW-1:0]   ct_q;
	logic [AW-1:0]   tat_q;
	logic [AW-1:0]   resp_q;
	logic [AW-1:0]   sum_tat_q;
	logic [AW-1:0]   sum_wt_q;
	logic [AW-1:0]   sum_bt_q;

	// table ports
	logic            wr_en;
	logic [AB-1:0]   wr_addr;
	logic [DW-1:0]   wr_data;
	logic            rd_en;
	logic [AB-1:0]   rd_addr;
	logic [DW-1:0]   rd_data;

	// fields of the record read back
	logic [SW-1:0]   rd_bt;
	logic [SW-1:0]   rd_arr;
	logic [ID_W-1:0] rd_id;
	logic            rd_cls;

	// shared unit
	alu_op_t         alu_op;
	logic [AW-1:0]   alu_a;
	logic [AW-1:0]   alu_b;
	logic [AW-1:0]   alu_res;
	logic            alu_borrow;

	logic [CW-1:0]   k_dec;
	logic [DW-1:0]   new_rec;
	logic            out_take;

	assign rd_bt   = rd_data[SW-1:0];
	assign rd_arr  = rd_data[2*SW-1:SW];
	assign rd_id   = rd_data[2*SW+ID_W-1:2*SW];
	assign rd_cls  = rd_data[DW-1];
	assign k_dec   = k_q - 1'b1;
	assign new_rec = {new_cls_q, new_id_q, new_arr_q, new_bt_q};
	assign out_take = (state_q == S_OUT) && !out_stall;

	mfs_table #(
		.DEPTH (MAX_PROCS),
		.AB    (AB),
		.DW    (DW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mfs_alu #(
		.W (AW)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	// operand selection for the shared unit
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_INS_CMP: begin
				// borrow means the stored key sorts after the new one
				alu_op = ALU_SUB;
				alu_a  = AW'({~new_cls_q, new_arr_q});
				alu_b  = AW'({~rd_cls, rd_arr});
			end
			S_ST: begin
				alu_op = ALU_SUB;
				alu_a  = run_q;
				alu_b  = AW'(rd_arr);
			end
			S_CT: begin
				alu_a = st_q;
				alu_b = AW'(cur_bt_q);
			end
			S_TAT: begin
				alu_op = ALU_SUB;
				alu_a  = ct_q;
				alu_b  = AW'(cur_arr_q);
			end
			S_RT: begin
				alu_op = ALU_SUB;
				alu_a  = st_q;
				alu_b  = AW'(cur_arr_q);
			end
			S_STAT: begin
				alu_a = sum_tat_q;
				alu_b = tat_q;
			end
			S_SWT: begin
				alu_a = sum_wt_q;
				alu_b = resp_q;
			end
			S_SBT: begin
				alu_a = sum_bt_q;
				alu_b = AW'(cur_bt_q);
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	// table access: insertion shifts and schedule reads
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = k_q[AB-1:0];
		wr_data = new_rec;
		rd_en   = 1'b0;
		rd_addr = k_dec[AB-1:0];
		case (state_q)
			S_INS_RD: begin
				if (k_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			S_INS_CMP: begin
				wr_en = 1'b1;
				if (alu_borrow) begin
					wr_data = rd_data;
				end
			end
			S_SCH_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AB-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			k_q        <= '0;
			idx_q      <= '0;
			overflow_q <= 1'b0;
			last_rec_q <= 1'b0;
			last_res_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_rec_q <= last_record;
						if (cnt_q < CW'(MAX_PROCS)) begin
							k_q     <= cnt_q;
							state_q <= S_INS_RD;
						end else begin
							overflow_q <= 1'b1;
							if (last_record) begin
								idx_q   <= '0;
								state_q <= S_SCH_RD;
							end
						end
					end
				end
				S_INS_RD: begin
					if (k_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						idx_q   <= '0;
						state_q <= last_rec_q ? S_SCH_RD : S_IDLE;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (alu_borrow) begin
						k_q     <= k_dec;
						state_q <= S_INS_RD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						idx_q   <= '0;
						state_q <= last_rec_q ? S_SCH_RD : S_IDLE;
					end
				end
				S_SCH_RD:  state_q <= S_ST;
				S_ST:      state_q <= S_CT;
				S_CT:      state_q <= S_TAT;
				S_TAT:     state_q <= S_RT;
				S_RT:      state_q <= S_STAT;
				S_STAT:    state_q <= S_SWT;
				S_SWT:     state_q <= S_SBT;
				S_SBT: begin
					last_res_q <= ((idx_q + 1'b1) == cnt_q);
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						if (last_res_q) begin
							cnt_q      <= '0;
							overflow_q <= 1'b0;
							state_q    <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SCH_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// loaded record capture
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			new_id_q  <= process_id;
			new_arr_q <= arrival[SW-1:0];
			new_bt_q  <= burst[SW-1:0];
			new_cls_q <= system_class;
		end
	end

	// clock and running sums, cleared at the start of each schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= '0;
			sum_tat_q <= '0;
			sum_wt_q  <= '0;
			sum_bt_q  <= '0;
		end else begin
			if (state_q != S_SCH_RD && state_q != S_ST && state_q != S_CT &&
				state_q != S_TAT && state_q != S_RT && state_q != S_STAT &&
				state_q != S_SWT && state_q != S_SBT && state_q != S_OUT) begin
				run_q     <= '0;
				sum_tat_q <= '0;
				sum_wt_q  <= '0;
				sum_bt_q  <= '0;
			end else begin
				case (state_q)
					S_CT:    run_q     <= alu_res;
					S_STAT:  sum_tat_q <= alu_res;
					S_SWT:   sum_wt_q  <= alu_res;
					S_SBT:   sum_bt_q  <= alu_res;
					default: run_q     <= run_q;
				endcase
			end
		end
	end

	// per-process times
	always_ff @(posedge clk) begin
		case (state_q)
			S_ST: begin
				cur_id_q  <= rd_id;
				cur_arr_q <= rd_arr;
				cur_bt_q  <= rd_bt;
				st_q      <= alu_borrow ? AW'(rd_arr) : run_q;
			end
			S_CT:    ct_q   <= alu_res;
			S_TAT:   tat_q  <= alu_res;
			S_RT:    resp_q <= alu_res;
			default: st_q   <= st_q;
		endcase
	end

	// handshake and result fields
	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = (state_q == S_OUT);
	assign result_id       = cur_id_q;
	assign start_time      = st_q[OUT_TIME_W-1:0];
	assign completion_time = ct_q[OUT_TIME_W-1:0];
	assign turnaround      = tat_q[OUT_TIME_W-1:0];
	// waiting equals response: completion - arrival - burst = start - arrival
	assign waiting         = resp_q[OUT_TIME_W-1:0];
	assign response        = resp_q[OUT_TIME_W-1:0];
	assign sum_turnaround  = sum_tat_q[SUM_W-1:0];
	assign sum_waiting     = sum_wt_q[SUM_W-1:0];
	assign sum_burst       = sum_bt_q[SUMB_W-1:0];
	// completions never decrease, so the latest one is the makespan
	assign makespan        = ct_q[OUT_TIME_W-1:0];
	assign dropped         = overflow_q;
	assign last_result     = last_res_q;

`ifndef SYNTH
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_PROCS))
		else $error("record count beyond table depth");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && last_result) |=> (cnt_q == '0 && !dropped && !out_valid))
		else $error("set not cleared after the final result");
`endif

endmodule

// ----- sim/multilevel_fcfs_schedule_timing_tb.sv -----
`timescale 1ns / 100ps
// multilevel_fcfs_schedule_timing_tb: self-checking bench for the multilevel fcfs timing block
// depends on mfs_pkg and multilevel_fcfs_schedule_timing; predicts each schedule in place
module multilevel_fcfs_schedule_timing_tb;
	import mfs_pkg::*;

	localparam int TBL_DEPTH   = MAX_PROCS_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 140;
	localparam int SHOWN_ERRORS = 10;
	localparam logic SYS_CLASS  = 1'b1;
	localparam logic USER_CLASS = 1'b0;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [IN_TIME_W-1:0] arrival;
		logic [IN_TIME_W-1:0] burst;
		logic                 sys;
		logic                 last;
	} proc_rec_t;

	typedef struct packed {
		logic [ID_W-1:0]       id;
		logic [OUT_TIME_W-1:0] start;
		logic [OUT_TIME_W-1:0] finish;
		logic [OUT_TIME_W-1:0] tat;
		logic [OUT_TIME_W-1:0] wait_t;
		logic [OUT_TIME_W-1:0] resp;
		logic [SUM_W-1:0]      sum_tat;
		logic [SUM_W-1:0]      sum_wait;
		logic [SUMB_W-1:0]     sum_bt;
		logic [OUT_TIME_W-1:0] span;
		logic                  drop;
		logic                  last;
	} timing_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [ID_W-1:0] process_id;
	logic [IN_TIME_W-1:0] arrival;
	logic [IN_TIME_W-1:0] burst;
	logic system_class;
	logic last_record;
	logic out_valid;
	logic out_stall;
	logic [ID_W-1:0] result_id;
	logic [OUT_TIME_W-1:0] start_time;
	logic [OUT_TIME_W-1:0] completion_time;
	logic [OUT_TIME_W-1:0] turnaround;
	logic [OUT_TIME_W-1:0] waiting;
	logic [OUT_TIME_W-1:0] response;
	logic [SUM_W-1:0] sum_turnaround;
	logic [SUM_W-1:0] sum_waiting;
	logic [SUMB_W-1:0] sum_burst;
	logic [OUT_TIME_W-1:0] makespan;
	logic dropped;
	logic last_result;

	// shadow copy of the record table
	logic [ID_W-1:0]      tbl_id  [TBL_DEPTH];
	logic [IN_TIME_W-1:0] tbl_arr [TBL_DEPTH];
	logic [IN_TIME_W-1:0] tbl_bst [TBL_DEPTH];
	logic                 tbl_sys [TBL_DEPTH];
	int   tbl_count = 0;
	logic tbl_over  = 1'b0;

	timing_t expected_timing[$];

	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit rx_hold = 1'b0;
	bit out_taken = 1'b0;
	int fail_count = 0;
	int idle_cycles = 0;
	int records_sent = 0;
	int records_dropped = 0;
	int sets_run = 0;
	int results_checked = 0;

	multilevel_fcfs_schedule_timing DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.process_id(process_id),
		.arrival(arrival),
		.burst(burst),
		.system_class(system_class),
		.last_record(last_record),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_id(result_id),
		.start_time(start_time),
		.completion_time(completion_time),
		.turnaround(turnaround),
		.waiting(waiting),
		.response(response),
		.sum_turnaround(sum_turnaround),
		.sum_waiting(sum_waiting),
		.sum_burst(sum_burst),
		.makespan(makespan),
		.dropped(dropped),
		.last_result(last_result)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// fcfs over system class, then user class, clock carried across
	task automatic predict_schedule();
		int order[$];
		int base;
		int k;
		int e;
		longint unsigned now_t, at, bt, st, ct;
		longint unsigned tat_v, wt_v, rt_v;
		longint unsigned s_tat, s_wt, s_bt, span;
		timing_t t;
		now_t = 0;
		s_tat = 0;
		s_wt = 0;
		s_bt = 0;
		span = 0;
		for (int c = 0; c < 2; c++) begin
			base = order.size();
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_sys[i] != ((c == 0) ? SYS_CLASS : USER_CLASS))
					continue;
				// stable insertion: equal arrivals keep load order
				k = order.size();
				while (k > base && tbl_arr[order[k - 1]] > tbl_arr[i])
					k--;
				order.insert(k, i);
			end
		end
		for (int n = 0; n < order.size(); n++) begin
			e = order[n];
			at = tbl_arr[e];
			bt = tbl_bst[e];
			st = (now_t > at) ? now_t : at;
			ct = st + bt;
			tat_v = ct - at;
			wt_v = tat_v - bt;
			rt_v = st - at;
			now_t = ct;
			s_tat += tat_v;
			s_wt += wt_v;
			s_bt += bt;
			if (ct > span)
				span = ct;
			t.id = tbl_id[e];
			t.start = st[OUT_TIME_W-1:0];
			t.finish = ct[OUT_TIME_W-1:0];
			t.tat = tat_v[OUT_TIME_W-1:0];
			t.wait_t = wt_v[OUT_TIME_W-1:0];
			t.resp = rt_v[OUT_TIME_W-1:0];
			t.sum_tat = s_tat[SUM_W-1:0];
			t.sum_wait = s_wt[SUM_W-1:0];
			t.sum_bt = s_bt[SUMB_W-1:0];
			t.span = span[OUT_TIME_W-1:0];
			t.drop = tbl_over;
			t.last = (n == order.size() - 1);
			expected_timing.push_back(t);
		end
		tbl_count = 0;
		tbl_over = 1'b0;
	endtask

	// store or drop one accepted record, schedule on the last one
	task automatic predict_record(input proc_rec_t rec);
		if (tbl_count < TBL_DEPTH) begin
			tbl_id[tbl_count] = rec.id;
			tbl_arr[tbl_count] = rec.arrival;
			tbl_bst[tbl_count] = rec.burst;
			tbl_sys[tbl_count] = rec.sys;
			tbl_count++;
		end else begin
			tbl_over = 1'b1;
			records_dropped++;
		end
		if (rec.last) begin
			predict_schedule();
			sets_run++;
		end
	endtask

	function automatic proc_rec_t make_rec(input int id, input int arr, input int bst,
		input logic sys, input logic last);
		proc_rec_t r;
		r.id = ID_W'(id);
		r.arrival = IN_TIME_W'(arr);
		r.burst = IN_TIME_W'(bst);
		r.sys = sys;
		r.last = last;
		return r;
	endfunction

	// random content: mostly close arrivals so the queues overlap and tie
	function automatic proc_rec_t random_rec(input logic last);
		int sel;
		proc_rec_t r;
		r.id = ID_W'($urandom_range(0, 255));
		r.arrival = ($urandom_range(0, 2) == 0) ? IN_TIME_W'($urandom_range(0, 65535)) :
			IN_TIME_W'($urandom_range(0, 40));
		sel = $urandom_range(0, 9);
		if (sel == 0)
			r.burst = '0;
		else if (sel < 7)
			r.burst = IN_TIME_W'($urandom_range(1, 20));
		else
			r.burst = IN_TIME_W'($urandom_range(0, 65535));
		r.sys = 1'($urandom_range(0, 1));
		r.last = last;
		return r;
	endfunction

	// drive one record at the falling edge and hold it until taken
	task automatic send_record(input proc_rec_t rec);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		process_id <= rec.id;
		arrival <= rec.arrival;
		burst <= rec.burst;
		system_class <= rec.sys;
		last_record <= rec.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_record(rec);
		records_sent++;
	endtask

	task automatic send_random_set(input int len);
		for (int i = 0; i < len; i++)
			send_record(random_rec(i == len - 1));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_timing.size() != 0)
			@(posedge clk);
	endtask

	// receiver hold-off, counted here while the sender keeps going
	task automatic hold_results(input int cycles);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold = 1'b0;
	endtask

	task automatic test_single_record();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_record(make_rec(255, 65535, 65535, SYS_CLASS, 1'b1));
	endtask

	// field extremes, zero burst, both classes
	task automatic test_field_extremes();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_record(make_rec(0, 0, 0, USER_CLASS, 1'b0));
		send_record(make_rec(255, 65535, 65535, SYS_CLASS, 1'b0));
		send_record(make_rec(8'h55, 16'h5555, 16'hAAAA, USER_CLASS, 1'b0));
		send_record(make_rec(8'hAA, 16'hAAAA, 16'h5555, SYS_CLASS, 1'b1));
	endtask

	// equal arrivals must keep load order in each class
	task automatic test_equal_arrivals();
		send_record(make_rec(1, 5, 3, USER_CLASS, 1'b0));
		send_record(make_rec(2, 5, 2, SYS_CLASS, 1'b0));
		send_record(make_rec(3, 5, 0, USER_CLASS, 1'b1));
	endtask

	// full table, then a dropped last record that still starts the schedule
	task automatic test_table_overflow();
		for (int i = 0; i < TBL_DEPTH; i++)
			send_record(make_rec(16 + i, (i * 7) % 5, i + 1, i[0] ? SYS_CLASS : USER_CLASS, 1'b0));
		send_record(make_rec(99, 0, 1, SYS_CLASS, 1'b1));
	endtask

	// mostly short sets, some longer up to a full table, a few overflowing
	task automatic test_random_sets();
		int first;
		int sel;
		first = records_sent;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		while (records_sent - first < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 7)
				send_random_set($urandom_range(1, 6));
			else if (sel < 9)
				send_random_set($urandom_range(7, 16));
			else
				send_random_set($urandom_range(17, 20));
		end
	endtask

	task automatic test_back_to_back();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_random_set(3);
		send_random_set(5);
		send_random_set(12);
	endtask

	// results held back while the next set is offered against a stalled input
	task automatic test_fill_under_hold();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		fork
			hold_results(HOLD_CYCLES);
		join_none
		send_random_set(8);
		send_random_set(6);
		wait_drained();
	endtask

	// sender pauses until the schedule has fully drained
	task automatic test_drain_pause();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_random_set(4);
		wait_drained();
		send_random_set(3);
		wait_drained();
		send_random_set(4);
	endtask

	task automatic check_field(input string fname, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			if (fail_count <= SHOWN_ERRORS)
				$display("mismatch on %s: expected %0d, got %0d", fname, exp_v, act_v);
		end
	endtask

	// receiver stall: random gap after each taken item, or the long hold
	initial begin : result_stall
		int gap;
		gap = 0;
		out_stall = 1'b1;
		forever begin
			@(negedge clk);
			if (out_taken)
				gap = rx_idle ? $urandom_range(0, 7) : 0;
			if (rx_hold)
				out_stall <= 1'b1;
			else if (gap > 0) begin
				out_stall <= 1'b1;
				gap--;
			end else
				out_stall <= 1'b0;
		end
	end

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin : result_check
		timing_t want;
		out_taken = arst_n && out_valid && !out_stall;
		if (out_taken) begin
			if (expected_timing.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOWN_ERRORS)
					$display("unexpected result item, id %0d", result_id);
			end else begin
				want = expected_timing.pop_front();
				check_field("result_id", 32'(want.id), 32'(result_id));
				check_field("start_time", 32'(want.start), 32'(start_time));
				check_field("completion_time", 32'(want.finish), 32'(completion_time));
				check_field("turnaround", 32'(want.tat), 32'(turnaround));
				check_field("waiting", 32'(want.wait_t), 32'(waiting));
				check_field("response", 32'(want.resp), 32'(response));
				check_field("sum_turnaround", 32'(want.sum_tat), 32'(sum_turnaround));
				check_field("sum_waiting", 32'(want.sum_wait), 32'(sum_waiting));
				check_field("sum_burst", 32'(want.sum_bt), 32'(sum_burst));
				check_field("makespan", 32'(want.span), 32'(makespan));
				check_field("dropped", 32'(want.drop), 32'(dropped));
				check_field("last_result", 32'(want.last), 32'(last_result));
				results_checked++;
			end
		end
	end

	// end the run when no item moves on either side for too long
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		process_id = '0;
		arrival = '0;
		burst = '0;
		system_class = 1'b0;
		last_record = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_single_record();
		test_field_extremes();
		test_equal_arrivals();
		test_table_overflow();
		test_random_sets();
		test_back_to_back();
		test_fill_under_hold();
		test_drain_pause();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d schedules from %0d records, %0d of them dropped on a full table",
			sets_run, records_sent, records_dropped);
		$display("checked %0d result items under random and held-off stalls", results_checked);
		if (fail_count == 0 && expected_timing.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
